// ----- rtl/cfb_pkg.sv -----
package cfb_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int ADDR_W = 4;
	localparam int APB_W  = 32;

	// reset values of the header registers
	localparam logic [BYTE_W-1:0] SYNC_RST  = 8'hA5;
	localparam logic [BYTE_W-1:0] TYPE_RST  = 8'h21;
	localparam logic [BYTE_W-1:0] FLAGS_RST = 8'h00;
	localparam logic [BYTE_W-1:0] LEN_RST   = 8'd200;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_SYNC  = 2'd0;
	localparam logic [1:0] REG_TYPE  = 2'd1;
	localparam logic [1:0] REG_FLAGS = 2'd2;
	localparam logic [1:0] REG_LEN   = 2'd3;

	// byte_kind codes
	localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHECKSUM = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_byte;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] header_flags;
		logic [BYTE_W-1:0] payload_length;
	} cfg_t;

	// one accepted item, as held for the emitter
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              close;
		logic [BYTE_W-1:0] lrc;
	} item_t;

	// accept event handed to the emitter
	typedef struct packed {
		logic accept;
		logic hdr;
	} acc_ev_t;

	function automatic logic [BYTE_W-1:0] negate8(input logic [BYTE_W-1:0] v);
		return BYTE_W'(~v + 1'b1);
	endfunction

endpackage

// ----- rtl/cfb_regs.sv -----
module cfb_regs import cfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output cfg_t              cfg
);

	cfg_t              cfg_q;
	logic              wr_en;
	logic [1:0]        idx;
	logic [BYTE_W-1:0] rd_byte;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte      <= SYNC_RST;
			cfg_q.frame_type     <= TYPE_RST;
			cfg_q.header_flags   <= FLAGS_RST;
			cfg_q.payload_length <= LEN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SYNC:  cfg_q.sync_byte      <= pwdata[BYTE_W-1:0];
				REG_TYPE:  cfg_q.frame_type     <= pwdata[BYTE_W-1:0];
				REG_FLAGS: cfg_q.header_flags   <= pwdata[BYTE_W-1:0];
				REG_LEN:   cfg_q.payload_length <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SYNC:  rd_byte = cfg_q.sync_byte;
			REG_TYPE:  rd_byte = cfg_q.frame_type;
			REG_FLAGS: rd_byte = cfg_q.header_flags;
			REG_LEN:   rd_byte = cfg_q.payload_length;
			default:   rd_byte = '0;
		endcase
	end

	assign prdata = {{(APB_W-BYTE_W){1'b0}}, rd_byte};
	assign cfg    = cfg_q;

endmodule

// ----- rtl/cfb_track.sv -----
module cfb_track import cfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              s_tvalid,
	input  logic [BYTE_W-1:0] s_tdata,
	output logic              s_tready,
	input  logic              done,
	output logic              item_valid,
	output item_t             item,
	output acc_ev_t           acc
);

	logic [BYTE_W-1:0] count_q;
	logic [BYTE_W-1:0] sum_q;
	logic              valid_s1;
	item_t             item_s1;

	logic              accept;
	logic [BYTE_W:0]   new_count;
	logic [BYTE_W:0]   eff_len;
	logic [BYTE_W-1:0] new_sum;
	logic              close;

	assign s_tready  = !valid_s1 || done;
	assign accept    = s_tvalid && s_tready;
	assign new_count = {1'b0, count_q} + 1'b1;
	// a length of zero means 256
	assign eff_len   = (cfg.payload_length == '0) ? {1'b1, {BYTE_W{1'b0}}}
		: {1'b0, cfg.payload_length};
	assign close     = new_count >= eff_len;
	assign new_sum   = BYTE_W'(sum_q + s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (close) begin
					count_q <= '0;
					sum_q   <= '0;
				end else begin
					count_q <= new_count[BYTE_W-1:0];
					sum_q   <= new_sum;
				end
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte <= s_tdata;
			item_s1.close     <= close;
			item_s1.lrc       <= negate8(new_sum);
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;
	assign acc.accept = accept;
	assign acc.hdr    = (count_q == '0);

endmodule

// ----- rtl/cfb_emit.sv -----
module cfb_emit import cfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              item_valid,
	input  item_t             item,
	input  acc_ev_t           acc,
	output logic              done,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);

	typedef enum logic [6:0] {
		PH_H0  = 7'b0000001,
		PH_H1  = 7'b0000010,
		PH_H2  = 7'b0000100,
		PH_H3  = 7'b0001000,
		PH_H4  = 7'b0010000,
		PH_PAY = 7'b0100000,
		PH_LRC = 7'b1000000
	} phase_t;

	phase_t            phase_q;
	phase_t            phase_nx;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [KIND_W-1:0] out_kind_q;
	logic              out_end_q;
	logic              out_last_q;

	logic              step;
	logic              last;
	logic [BYTE_W-1:0] byte_c;
	logic [KIND_W-1:0] kind_c;
	logic [BYTE_W-1:0] hdr_chk;

	assign hdr_chk = negate8(BYTE_W'(cfg.sync_byte + cfg.frame_type
		+ cfg.header_flags + cfg.payload_length));

	assign step = item_valid && (!out_valid_q || m_tready);
	assign done = step && last;

	always_comb begin
		last     = 1'b0;
		phase_nx = phase_q;
		byte_c   = item.data_byte;
		kind_c   = KIND_HEADER;
		case (phase_q)
			PH_H0: begin
				byte_c   = cfg.sync_byte;
				phase_nx = PH_H1;
			end
			PH_H1: begin
				byte_c   = cfg.frame_type;
				phase_nx = PH_H2;
			end
			PH_H2: begin
				byte_c   = cfg.header_flags;
				phase_nx = PH_H3;
			end
			PH_H3: begin
				byte_c   = cfg.payload_length;
				phase_nx = PH_H4;
			end
			PH_H4: begin
				byte_c   = hdr_chk;
				phase_nx = PH_PAY;
			end
			PH_PAY: begin
				byte_c   = item.data_byte;
				kind_c   = KIND_PAYLOAD;
				last     = !item.close;
				phase_nx = PH_LRC;
			end
			PH_LRC: begin
				byte_c   = item.lrc;
				kind_c   = KIND_CHECKSUM;
				last     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PAY;
			out_valid_q <= 1'b0;
		end else begin
			// a new item always replaces the phase; it only arrives as the old one ends
			if (acc.accept) begin
				phase_q <= acc.hdr ? PH_H0 : PH_PAY;
			end else if (step && !last) begin
				phase_q <= phase_nx;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= byte_c;
			out_kind_q <= kind_c;
			out_end_q  <= (phase_q == PH_LRC);
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_end_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule

// ----- rtl/checksummed_frame_builder_top.sv -----
// Frame builder: header (5 items), payload items, LRC item per frame.
// An accepted item is registered in the tracker, then its bytes go through the
// single output register, one byte a cycle while m_tready allows: 5 header bytes
// first for an item that opens a frame, the LRC byte after one that closes it.
// Reset: arst_n async low; clears frame count, sum, valids; header regs to defaults.
module checksummed_frame_builder_top import cfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// payload input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	// framed output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	output logic [2:0]        m_tuser,   // [1:0] byte_kind, [2] frame_end
	output logic              m_tlast,   // run_last: last result of the input item
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready
);

	cfg_t    cfg;
	item_t   item;
	acc_ev_t acc;
	logic    item_valid;
	logic    done;

	// no wait states on the register port
	assign pready = 1'b1;

	// sync, type, flags, length registers
	cfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// frame count and running sum, updated as each item is taken;
	// holds the item with its close flag and LRC until fully emitted
	cfb_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s_tvalid   (s_tvalid),
		.s_tdata    (s_tdata),
		.s_tready   (s_tready),
		.done       (done),
		.item_valid (item_valid),
		.item       (item),
		.acc        (acc)
	);

	// walks header / payload / LRC phases into the output register;
	// the next item is taken in the cycle its predecessor's last byte goes out
	cfb_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.acc        (acc),
		.done       (done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- sim/checksummed_frame_builder_checker.sv -----
module checksummed_frame_builder_checker import cfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	input  logic [2:0]        m_tuser,   // [1:0] byte_kind, [2] frame_end
	input  logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output int unsigned       mismatches,
	output int unsigned       backlog,
	output int unsigned       bytes_checked,
	output int unsigned       frames_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [KIND_W-1:0] byte_kind;
		logic              frame_end;
		logic              run_last;
	} frame_byte_t;

	cfg_t              hdr_regs;
	logic [BYTE_W-1:0] frame_count;
	logic [BYTE_W-1:0] frame_sum;
	frame_byte_t       frame_bytes_due[$];
	int unsigned       n_bad = 0;
	int unsigned       n_checked = 0;
	int unsigned       n_frames = 0;

	function automatic void queue_frame_byte(input logic [BYTE_W-1:0] b,
			input logic [KIND_W-1:0] kind, input logic fend, input logic last);
		frame_byte_t fb;
		fb.out_byte  = b;
		fb.byte_kind = kind;
		fb.frame_end = fend;
		fb.run_last  = last;
		frame_bytes_due.push_back(fb);
	endfunction

	// bytes one accepted payload item puts on the wire
	function automatic void frame_payload_byte(input logic [BYTE_W-1:0] d);
		logic [BYTE_W-1:0] hsum;
		logic [8:0]        limit;
		logic [8:0]        count_next;
		if (frame_count == '0) begin
			hsum = hdr_regs.sync_byte + hdr_regs.frame_type + hdr_regs.header_flags
				+ hdr_regs.payload_length;
			queue_frame_byte(hdr_regs.sync_byte, KIND_HEADER, 1'b0, 1'b0);
			queue_frame_byte(hdr_regs.frame_type, KIND_HEADER, 1'b0, 1'b0);
			queue_frame_byte(hdr_regs.header_flags, KIND_HEADER, 1'b0, 1'b0);
			queue_frame_byte(hdr_regs.payload_length, KIND_HEADER, 1'b0, 1'b0);
			queue_frame_byte(8'(8'd0 - hsum), KIND_HEADER, 1'b0, 1'b0);
		end
		frame_sum = frame_sum + d;
		// length 0 means 256
		limit = (hdr_regs.payload_length == '0) ? 9'd256 : {1'b0, hdr_regs.payload_length};
		count_next = {1'b0, frame_count} + 9'd1;
		if (count_next >= limit) begin
			queue_frame_byte(d, KIND_PAYLOAD, 1'b0, 1'b0);
			queue_frame_byte(8'(8'd0 - frame_sum), KIND_CHECKSUM, 1'b1, 1'b1);
			frame_count = '0;
			frame_sum   = '0;
		end else begin
			queue_frame_byte(d, KIND_PAYLOAD, 1'b0, 1'b1);
			frame_count = count_next[BYTE_W-1:0];
		end
	endfunction

	function automatic int unsigned field_differs(input string name,
			input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			hdr_regs.sync_byte      = SYNC_RST;
			hdr_regs.frame_type     = TYPE_RST;
			hdr_regs.header_flags   = FLAGS_RST;
			hdr_regs.payload_length = LEN_RST;
			frame_count = '0;
			frame_sum   = '0;
			frame_bytes_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_SYNC:  hdr_regs.sync_byte      = pwdata[BYTE_W-1:0];
					REG_TYPE:  hdr_regs.frame_type     = pwdata[BYTE_W-1:0];
					REG_FLAGS: hdr_regs.header_flags   = pwdata[BYTE_W-1:0];
					REG_LEN:   hdr_regs.payload_length = pwdata[BYTE_W-1:0];
					default:   ;
				endcase
			end
			if (s_tvalid && s_tready)
				frame_payload_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (frame_bytes_due.size() == 0) begin
					$error("output item with nothing expected: out_byte 0x%0h", m_tdata);
					n_bad++;
				end else begin
					want = frame_bytes_due.pop_front();
					n_bad += field_differs("out_byte", want.out_byte, m_tdata);
					n_bad += field_differs("byte_kind", 8'(want.byte_kind), 8'(m_tuser[1:0]));
					n_bad += field_differs("frame_end", 8'(want.frame_end), 8'(m_tuser[2]));
					n_bad += field_differs("run_last", 8'(want.run_last), 8'(m_tlast));
					n_checked++;
					if (want.frame_end)
						n_frames++;
				end
			end
		end
		mismatches    <= n_bad;
		backlog       <= frame_bytes_due.size();
		bytes_checked <= n_checked;
		frames_closed <= n_frames;
	end

endmodule

// ----- sim/tb_checksummed_frame_builder_top.sv -----
module tb_checksummed_frame_builder_top;
	import cfb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS  = 170;
	localparam int unsigned LEN0_ITEMS    = 16;      // items sent into a length-0 frame
	localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int unsigned SETTLE_CYCLES = 8;       // extra wait after the backlog drains
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;    // [7:0] data_byte
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;    // [7:0] out_byte
	logic [2:0]        m_tuser;    // [1:0] byte_kind, [2] frame_end
	logic              m_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0]  pwdata;
	logic [APB_W-1:0]  prdata;
	logic              pready;

	int unsigned mismatches;
	int unsigned backlog;
	int unsigned bytes_checked;
	int unsigned frames_closed;

	// handshake shaping, shared between the item source and the sink
	bit          src_free  = 1'b0;   // no gaps on the input side
	bit          sink_free = 1'b0;   // no stalls on the output side
	bit          hold_req  = 1'b0;   // ask the sink for one long hold-off
	int unsigned n_sent    = 0;
	int unsigned n_settings = 0;
	int unsigned n_holds   = 0;

	checksummed_frame_builder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	checksummed_frame_builder_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.mismatches    (mismatches),
		.backlog       (backlog),
		.bytes_checked (bytes_checked),
		.frames_closed (frames_closed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// idle stretch: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// All tasks below are entered just after a rising edge.

	// APB write: setup cycle, then access cycle; pready is tied high in the block
	task automatic reg_write(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= APB_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_header(input logic [BYTE_W-1:0] sync, input logic [BYTE_W-1:0] ftype,
			input logic [BYTE_W-1:0] flags, input logic [BYTE_W-1:0] len);
		reg_write(REG_SYNC, sync);
		reg_write(REG_TYPE, ftype);
		reg_write(REG_FLAGS, flags);
		reg_write(REG_LEN, len);
		n_settings++;
	endtask

	// Offer one payload item and hold it until taken. tvalid stays high between
	// back-to-back items so it is never dropped and raised in the same step.
	task automatic push_payload(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = src_free ? 0 : idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// Stop offering, then wait until every predicted byte has come out.
	// backlog is registered in the checker, hence the wait before it is read.
	task automatic settle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (backlog != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: random stalls, or one long hold-off on request so that the
	// block fills up and drops s_tready.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
				n_holds++;
			end else if (stall_left == 0 && !sink_free && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len();
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: covers a hung handshake and expected bytes that never arrive.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("run stopped after %0d cycles, %0d bytes still expected", cycles, backlog);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned rand_sent;
		int unsigned n_items;
		int unsigned r;
		logic [BYTE_W-1:0] len;
		bit pressure_done;

		rand_sent     = 0;
		pressure_done = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset header values, length 200: a frame is opened and left with four
		// bytes in it, extremes of the data field first.
		push_payload(8'h00);
		push_payload(8'hFF);
		push_payload(8'h5A);
		push_payload(8'hA5);
		settle();

		// Length dropped below the count mid-frame: next item closes it. The new
		// header values only show in the header after that.
		set_header(8'hFF, 8'h00, 8'hFF, 8'd3);
		push_payload(8'h80);
		repeat (6) push_payload(8'($urandom_range(0, 255)));
		settle();

		// Length 1: every item opens and closes a frame, seven bytes each.
		set_header(8'h00, 8'hFF, 8'h00, 8'd1);
		push_payload(8'h00);
		push_payload(8'hFF);
		push_payload(8'h01);
		push_payload(8'h80);
		push_payload(8'h7F);
		push_payload(8'hFE);
		settle();

		// Length 0 reads as 256: the frame stays open with 0 in its header; a
		// later, shorter length closes it on the next item.
		set_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'd0);
		repeat (LEN0_ITEMS) push_payload(8'($urandom_range(0, 255)));
		settle();

		// Random settings; short lengths dominate so that many frames close,
		// long ones leave frames open across the next setting.
		while (rand_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				len = 8'($urandom_range(1, 6));
			else if (r < 85)
				len = 8'($urandom_range(7, 24));
			else if (r < 95)
				len = 8'($urandom_range(200, 255));
			else
				len = 8'd0;
			set_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), len);
			src_free  = ($urandom_range(0, 3) == 0);
			sink_free = ($urandom_range(0, 3) == 0);
			n_items   = $urandom_range(4, 30);
			if (!pressure_done) begin
				// sink holds off while items keep coming back to back
				pressure_done = 1'b1;
				src_free  = 1'b1;
				n_items   = 48;
				hold_req  = 1'b1;
			end
			repeat (n_items) begin
				push_payload(8'($urandom_range(0, 255)));
				rand_sent++;
			end
			settle();
		end

		$display("%0d payload items under %0d header settings, %0d long receiver hold-off(s)",
			n_sent, n_settings, n_holds);
		$display("%0d output bytes compared, %0d frames closed", bytes_checked, frames_closed);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cfb_pkg.sv
rtl/cfb_regs.sv
rtl/cfb_track.sv
rtl/cfb_emit.sv
rtl/checksummed_frame_builder_top.sv
sim/checksummed_frame_builder_checker.sv
sim/tb_checksummed_frame_builder_top.sv
